### hdl/mh3_pkg.sv
// Package for the MurmurHash3 x86_32 block: constants, sequencer states and helpers.
package mh3_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NB_W   = 3;

  localparam logic [WORD_W-1:0] SCR_MUL_A  = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] SCR_MUL_B  = 32'h1b873593;
  localparam logic [WORD_W-1:0] MIX_ADD    = 32'he6546b64;
  localparam logic [WORD_W-1:0] FIN_MUL_A  = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FIN_MUL_B  = 32'hc2b2ae35;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd17;

  localparam logic [NB_W-1:0] NB_FULL = 3'd4;
  localparam logic [NB_W-1:0] NB_NONE = 3'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCR2,
    S_MIX,
    S_FIN1,
    S_FIN2,
    S_FIN3
  } state_t;

  function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
    rotl15 = {x[WORD_W-16:0], x[WORD_W-1:WORD_W-15]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
    rotl13 = {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
  endfunction

  // Keep the low nb bytes of a word, nb already clamped to 0..4.
  function automatic logic [WORD_W-1:0] byte_mask(input logic [NB_W-1:0] nb);
    case (nb)
      3'd0:    byte_mask = 32'h0000_0000;
      3'd1:    byte_mask = 32'h0000_00ff;
      3'd2:    byte_mask = 32'h0000_ffff;
      3'd3:    byte_mask = 32'h00ff_ffff;
      default: byte_mask = 32'hffff_ffff;
    endcase
  endfunction

endpackage

### hdl/mh3_mul.sv
// Shared 32x32 multiplier keeping the low product word in a register.
module mh3_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mh3_pkg::WORD_W-1:0]  a,
  input  logic [mh3_pkg::WORD_W-1:0]  b,
  output logic [mh3_pkg::WORD_W-1:0]  p
);

  logic [mh3_pkg::WORD_W-1:0] p_r;
  logic [mh3_pkg::WORD_W-1:0] p_nxt;

  assign p_nxt = a * b;  // low word only, modulo 2^32

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

### hdl/murmur3_32_hash_top.sv
// MurmurHash3 x86_32 streaming hasher: sequencer around one shared multiplier.
// A full non-last word is accepted with its first multiply, then takes the second
//   multiply and the mix before the next accept: the two dependent multiplies go
//   through the single shared multiplier. A last item runs S_SCR2 (skipped when
//   empty), S_MIX, S_FIN1, S_FIN2, then S_FIN3 until the output register is free.
// Reset (rst_n low, synchronous): seed returns to 17, message state clears, no result.
module murmur3_32_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: seed register
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_word, [34:32] bytes_valid, [39:35] zero
  input  logic        in_tlast,   // is_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] hash_value
  output logic        out_tuser   // [0] framing_error
);

  mh3_pkg::state_t state_r, state_nxt;

  logic [31:0] seed_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        mid_r, mid_nxt;
  logic        err_r, err_nxt;
  logic [2:0]  nb_r, nb_nxt;
  logic        last_r, last_nxt;

  logic [31:0] out_hash_r, out_hash_nxt;
  logic        out_err_r, out_err_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        accept;
  logic [2:0]  in_nb;
  logic [31:0] in_word;
  logic        out_free;

  logic        mul_en;
  logic [31:0] mul_a, mul_b, prod;

  logic [31:0] mix_x, mixed, tail, cnt_sum, fin_a;

  mh3_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Clamp byte count: 5..7 behave as a full word; drop bytes above the count.
  assign in_nb   = in_tdata[34] ? mh3_pkg::NB_FULL : in_tdata[34:32];
  assign in_word = in_tdata[31:0] & mh3_pkg::byte_mask(in_nb);

  assign in_tready = (state_r == mh3_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Body mix: rotate, times 5 as shift-add, add constant.
  assign mix_x   = mh3_pkg::rotl13(hash_r ^ prod);
  assign mixed   = (mix_x << 2) + mix_x + mh3_pkg::MIX_ADD;
  assign tail    = (nb_r != mh3_pkg::NB_NONE) ? (hash_r ^ prod) : hash_r;
  assign cnt_sum = cnt_r + {29'd0, nb_r};
  assign fin_a   = hash_r ^ (hash_r >> 16);

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    cnt_nxt       = cnt_r;
    mid_nxt       = mid_r;
    err_nxt       = err_r;
    nb_nxt        = nb_r;
    last_nxt      = last_r;
    out_hash_nxt  = out_hash_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_en        = 1'b0;
    mul_a         = in_word;
    mul_b         = mh3_pkg::SCR_MUL_A;

    case (state_r)
      mh3_pkg::S_IDLE: begin
        if (accept) begin
          nb_nxt   = in_nb;
          last_nxt = in_tlast;
          // A fresh message starts from the current seed.
          hash_nxt = mid_r ? hash_r : seed_r;
          if (!in_tlast && (in_nb != mh3_pkg::NB_FULL)) begin
            // Short non-last item: flag and drop it.
            err_nxt = 1'b1;
          end else if (in_nb == mh3_pkg::NB_NONE) begin
            state_nxt = mh3_pkg::S_MIX;
          end else begin
            mul_en    = 1'b1;
            state_nxt = mh3_pkg::S_SCR2;
          end
        end
      end
      mh3_pkg::S_SCR2: begin
        mul_en    = 1'b1;
        mul_a     = mh3_pkg::rotl15(prod);
        mul_b     = mh3_pkg::SCR_MUL_B;
        state_nxt = mh3_pkg::S_MIX;
      end
      mh3_pkg::S_MIX: begin
        if (!last_r) begin
          hash_nxt  = mixed;
          cnt_nxt   = cnt_sum;
          mid_nxt   = 1'b1;
          state_nxt = mh3_pkg::S_IDLE;
        end else begin
          hash_nxt  = ((nb_r == mh3_pkg::NB_FULL) ? mixed : tail) ^ cnt_sum;
          state_nxt = mh3_pkg::S_FIN1;
        end
      end
      mh3_pkg::S_FIN1: begin
        mul_en    = 1'b1;
        mul_a     = fin_a;
        mul_b     = mh3_pkg::FIN_MUL_A;
        state_nxt = mh3_pkg::S_FIN2;
      end
      mh3_pkg::S_FIN2: begin
        mul_en    = 1'b1;
        mul_a     = prod ^ (prod >> 13);
        mul_b     = mh3_pkg::FIN_MUL_B;
        state_nxt = mh3_pkg::S_FIN3;
      end
      mh3_pkg::S_FIN3: begin
        // Hold until the output register frees up, then load and start over.
        if (out_free) begin
          out_hash_nxt  = prod ^ (prod >> 16);
          out_err_nxt   = err_r;
          out_valid_nxt = 1'b1;
          cnt_nxt       = 32'd0;
          mid_nxt       = 1'b0;
          err_nxt       = 1'b0;
          state_nxt     = mh3_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mh3_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mh3_pkg::S_IDLE;
      seed_r      <= mh3_pkg::SEED_RESET;
      cnt_r       <= 32'd0;
      mid_r       <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mid_r       <= mid_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    hash_r     <= hash_nxt;
    nb_r       <= nb_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_hash_r;
  assign out_tuser  = out_err_r;

`ifndef NO_ASSERTIONS
  // A full non-last word is absorbed and marks the message as started.
  a_word_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tlast && (in_nb == mh3_pkg::NB_FULL)) |-> ##3
      (mid_r && state_r == mh3_pkg::S_IDLE))
    else $error("full word not absorbed in three cycles");

  // A short non-last item is flagged and dropped without leaving idle.
  a_short_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tlast && (in_nb != mh3_pkg::NB_FULL)) |=>
      (err_r && state_r == mh3_pkg::S_IDLE))
    else $error("short item not flagged");

  // Delivering a result clears the message state.
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mh3_pkg::S_FIN3 && out_free) |=>
      (out_valid_r && !mid_r && !err_r && cnt_r == 32'd0))
    else $error("message state not cleared at result");
`endif

endmodule

### bench/tb_murmur3_32_hash_top.sv
// Self-checking bench for the streaming MurmurHash3 x86_32 hasher with random stream pressure.
module tb_murmur3_32_hash_top;

  // Hash constants of the x86_32 variant, kept local so the bench model stands on its own.
  localparam logic [31:0] K_SCR_A   = 32'hcc9e2d51;
  localparam logic [31:0] K_SCR_B   = 32'h1b873593;
  localparam logic [31:0] K_MIX_ADD = 32'he6546b64;
  localparam logic [31:0] K_FIN_A   = 32'h85ebca6b;
  localparam logic [31:0] K_FIN_B   = 32'hc2b2ae35;
  localparam logic [31:0] K_SEED_RST = 32'd17;

  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int DRAIN_CYCLES    = 12;    // longest item latency plus margin
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        is_last;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] hash;
    logic        framing_err;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [31:0] data_word, [34:32] bytes_valid, [39:35] zero
  logic        in_tlast = 1'b0; // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] hash_value
  logic        out_tuser;       // [0] framing_error

  murmur3_32_hash_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Stimulus waiting for the driver, and digests the hasher still owes us.
  msg_item_t pending_items[$];
  digest_t   digests_due[$];
  msg_item_t in_flight;

  // Bench copy of the hasher state.
  logic [31:0] seed_copy   = K_SEED_RST;
  logic [31:0] hash_acc    = K_SEED_RST;
  logic [31:0] byte_total  = '0;
  logic        short_seen  = 1'b0;
  logic        in_message  = 1'b0;

  int in_idle_odds  = 0;   // 0 disables idling; else one burst per this many transactions
  int out_idle_odds = 0;
  int in_gap        = 0;
  int out_stall     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int phase_items    = 0;

  // ---------------------------------------------------------------------------
  // Hash arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_word(input logic [31:0] w);
    logic [31:0] t;
    t = w * K_SCR_A;
    t = rotl(t, 15);
    t = t * K_SCR_B;
    return t;
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] t;
    t = rotl(h ^ scramble_word(w), 13);
    t = t * 32'd5 + K_MIX_ADD;
    return t;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * K_FIN_A;
    t = t ^ (t >> 13);
    t = t * K_FIN_B;
    t = t ^ (t >> 16);
    return t;
  endfunction

  // Fold one accepted transaction into the bench state; queue a digest on message end.
  function automatic void absorb_item(input msg_item_t it);
    logic [31:0] h;
    logic [2:0]  nb;
    logic [31:0] keep;
    digest_t     d;
    h  = in_message ? hash_acc : seed_copy;
    nb = (it.nbytes > 3'd4) ? 3'd4 : it.nbytes;
    if (!it.is_last) begin
      // Short word before the end: flag it, drop the data.
      if (nb < 3'd4) begin
        short_seen = 1'b1;
      end else begin
        hash_acc   = mix_word(h, it.word);
        byte_total = byte_total + 32'd4;
        in_message = 1'b1;
      end
      return;
    end
    if (nb == 3'd4) begin
      h = mix_word(h, it.word);
    end else if (nb != 3'd0) begin
      keep = 32'hffffffff >> (32 - 8 * int'(nb));
      h = h ^ scramble_word(it.word & keep);
    end
    byte_total = byte_total + 32'(nb);
    d.hash        = avalanche(h ^ byte_total);
    d.framing_err = short_seen;
    digests_due = {digests_due, d};
    // Restart from the current seed for the next message.
    hash_acc   = seed_copy;
    byte_total = '0;
    short_seen = 1'b0;
    in_message = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: present the next pending item, hold it until accepted,
  // and insert random idle bursts between transactions.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready)
        absorb_item(in_flight);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_flight = pending_items.pop_front();
          in_tdata  <= {5'b0, in_flight.nbytes, in_flight.word};
          in_tlast  <= in_flight.is_last;
          in_tvalid <= 1'b1;
          if (in_idle_odds > 0 && $urandom_range(0, in_idle_odds - 1) == 0)
            in_gap = $urandom_range(1, 19);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compare each result transaction with the oldest digest due,
  // and stall the result side in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_t d;
    if (rst_n && out_tvalid && out_tready) begin
      if (digests_due.size() == 0) begin
        $error("unexpected result: hash_value %h framing_error %b", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        d = digests_due.pop_front();
        if (out_tdata !== d.hash) begin
          $error("hash_value mismatch: expected %h, actual %h", d.hash, out_tdata);
          mismatch_count++;
        end
        if (out_tuser !== d.framing_err) begin
          $error("framing_error mismatch: expected %b, actual %b", d.framing_err, out_tuser);
          mismatch_count++;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_idle_odds > 0 && $urandom_range(0, out_idle_odds - 1) == 0)
        out_stall = $urandom_range(1, 19);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    msg_item_t it;
    it.word    = w;
    it.nbytes  = nb;
    it.is_last = lst;
    pending_items = {pending_items, it};
    phase_items++;
  endtask

  // Mostly random words, with the all-zero and all-one corners now and then.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h00000000;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // One well-formed message of random length, sometimes broken by a short word.
  task automatic queue_random_message();
    int n_words;
    n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 11) == 0)
        push_item(rand_word(), 3'($urandom_range(0, 3)), 1'b0);
      if ($urandom_range(0, 7) == 0)
        push_item(rand_word(), 3'($urandom_range(5, 7)), 1'b0);
      else
        push_item(rand_word(), 3'd4, 1'b0);
    end
    push_item(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Wait until the hasher is idle: nothing queued, nothing owed, plus its latency.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || digests_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the seed register; call only while the hasher is idle.
  task automatic write_seed(input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_copy = value;
    if (!in_message)
      hash_acc = value;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] seed_plan[RAND_PHASES];
    seed_plan[0] = 32'h00000000;
    seed_plan[1] = 32'hffffffff;
    seed_plan[2] = 32'h00000001;
    seed_plan[3] = 32'h80000000;
    for (int p = 4; p < RAND_PHASES; p++)
      seed_plan[p] = $urandom;

    // Hold reset low, then release it.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset seed.
    in_idle_odds  = 6;
    out_idle_odds = 6;
    push_item(32'h00000000, 3'd0, 1'b1);       // empty message: finalized seed
    push_item(32'hffffffff, 3'd4, 1'b1);       // single full word
    push_item(32'h00000000, 3'd4, 1'b1);
    push_item(32'hffffffff, 3'd1, 1'b1);       // tails: upper bytes must be ignored
    push_item(32'hffffffff, 3'd2, 1'b1);
    push_item(32'hffffffff, 3'd3, 1'b1);
    push_item(32'ha5a5a5a5, 3'd5, 1'b1);       // oversized byte counts act as four
    push_item(32'h5a5a5a5a, 3'd6, 1'b1);
    push_item(32'h12345678, 3'd7, 1'b1);
    push_item(32'h00000000, 3'd4, 1'b0);       // multi-word message with a 3-byte tail
    push_item(32'hffffffff, 3'd4, 1'b0);
    push_item(32'hdeadbeef, 3'd3, 1'b1);
    push_item(32'h11223344, 3'd2, 1'b0);       // short words mid-message: dropped, flagged
    push_item(32'h00000000, 3'd0, 1'b0);
    push_item(32'hcafef00d, 3'd4, 1'b0);
    push_item(32'hffffffff, 3'd1, 1'b1);
    push_item(32'hffffffff, 3'd7, 1'b0);       // oversized non-last words count as full
    push_item(32'hffffffff, 3'd5, 1'b0);
    push_item(32'hffffffff, 3'd6, 1'b0);
    push_item(32'h87654321, 3'd0, 1'b1);
    push_item(32'hffffffff, 3'd3, 1'b0);       // error flag on an otherwise empty message
    push_item(32'h00000000, 3'd0, 1'b1);

    // Random phases, each under a new seed. Some phases stop mid-message so the
    // seed changes while a message is open; the old hash must carry on.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      write_seed(seed_plan[p]);
      @(negedge clk);
      if (p == RAND_PHASES - 1) begin
        in_idle_odds  = 0;
        out_idle_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       in_idle_odds = 0;
          1:       in_idle_odds = 3;
          default: in_idle_odds = 10;
        endcase
        case ($urandom_range(0, 2))
          0:       out_idle_odds = 0;
          1:       out_idle_odds = 3;
          default: out_idle_odds = 10;
        endcase
      end
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE)
        queue_random_message();
      if (p != RAND_PHASES - 1 && $urandom_range(0, 1) == 1) begin
        for (int i = $urandom_range(1, 3); i > 0; i--)
          push_item(rand_word(), 3'd4, 1'b0);
      end
    end

    // Drain, then report.
    wait_drained();
    if (mismatch_count == 0 && digests_due.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
